// ----- design/fed_pkg.sv -----
// Shared types and constants of the feedback echo delay.
`timescale 1ns / 1ps
package fed_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELAY = 2'd0,
    CFG_FBK   = 2'd1,
    CFG_MIX   = 2'd2
  } fed_cfg_idx_e;

  // Register widths and reset values
  localparam int unsigned DelayW = 15;
  localparam int unsigned GainW  = 15;
  localparam int unsigned MixW   = 16;

  localparam logic [DelayW-1:0] DelayRst = 15'd13230;
  localparam logic [GainW-1:0]  FbkRst   = 15'd14746;
  localparam logic [MixW-1:0]   MixRst   = 16'd11469;

  // Gain limits: feedback at most 0.95, mix at most fully wet
  localparam logic [GainW-1:0] FbkMax  = 15'd31130;
  localparam logic [MixW-1:0]  MixFull = 16'd32768;

  // Q0.15 product scaling
  localparam int unsigned FracW = 15;

  // Load enables of the multiply stages
  typedef struct packed {
    logic ld2;  // load stage 2 (wet and dry operands)
    logic ld3;  // load stage 3 (products)
  } fed_adv_t;

endpackage

// ----- design/feedback_echo_delay.sv -----
// Top level of the feedback echo delay: control, stores and pipeline.
`timescale 1ns / 1ps
// Feedback echo delay on signed fixed-point audio. Each input beat carries one
// sample; each output beat carries one mixed sample, in order. The line input
// (sample plus the feedback value written FEEDBACK_LAG samples earlier,
// saturated) goes into a delay line of LINE_DEPTH words; the wet sample is read
// delay_samples back (modulo the depth, so zero reads the sample just written).
// The wet sample times feedback_gain goes into the feedback store, and the
// output is the dry/wet crossfade set by mix_level. Products are shifted right
// arithmetically by 15 and saturated. feedback_gain is clamped to 31130 and
// mix_level to 32768 as they are written. Rate: one sample per clock while the
// output is taken and the input is not held for feedback. Both stores are read
// at the input beat; stage 1 forms the line sum and writes it back, stage 2
// holds the operands, the three multiplies load stage 3, and the final sum
// goes into the output register, which holds the beat until it is taken.
// When FEEDBACK_LAG is three or less, an input beat waits until the sample
// FEEDBACK_LAG earlier has written its feedback value, so at most
// FEEDBACK_LAG samples are then in stages 1 to 3. Both stores read as zero until
// written; fill flags track this, so no clearing pass follows reset.
// LINE_DEPTH must be a power of two. Configuration writes are taken in any
// cycle and are meant only while the block is idle.
module feedback_echo_delay import fed_pkg::*; #(
  parameter int unsigned LINE_DEPTH   = 32768,
  parameter int unsigned FEEDBACK_LAG = 128,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  // sample output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CfgIdxW-1:0]             cfg_index_i,
  input  logic [CfgDataW-1:0]            cfg_data_i
);

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);
  localparam int unsigned FP_W   = (FEEDBACK_LAG > 1) ? $clog2(FEEDBACK_LAG) : 1;
  localparam logic [FP_W-1:0] FpLast = FP_W'(FEEDBACK_LAG - 1);
  localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers. Clamp the gains on the way in, so the datapath
  // never sees an out-of-range value.
  // ---------------------------------------------------------------------------
  logic [DelayW-1:0] delay_q;
  logic [GainW-1:0]  fbk_q;
  logic [MixW-1:0]   mix_q;
  logic              cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayRst;
      fbk_q   <= FbkRst;
      mix_q   <= MixRst;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_DELAY: delay_q <= cfg_data_i[DelayW-1:0];
        CFG_FBK: begin
          fbk_q <= (cfg_data_i[GainW-1:0] > FbkMax) ? FbkMax : cfg_data_i[GainW-1:0];
        end
        CFG_MIX: mix_q <= (cfg_data_i > MixFull) ? MixFull : cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow. Each stage loads when it is empty or the stage after it
  // moves on, so bubbles collapse and the input keeps flowing into empty stages
  // while a finished sample waits in the output register.
  // ---------------------------------------------------------------------------
  logic s1_vq_q, s2_vq_q, s3_vq_q, out_vq_q;
  logic free1, free2, free3, out_en;
  logic in_acc, fb_hazard;
  fed_adv_t adv;

  assign out_en = !out_vq_q || out_ready_i;
  assign free3  = !s3_vq_q || out_en;
  assign free2  = !s2_vq_q || free3;
  assign free1  = !s1_vq_q || free2;

  assign in_ready_o = free1 && !fb_hazard;
  assign in_acc     = in_valid_i && in_ready_o;

  assign adv.ld2 = free2;
  assign adv.ld3 = free3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq_q  <= 1'b0;
      s2_vq_q  <= 1'b0;
      s3_vq_q  <= 1'b0;
      out_vq_q <= 1'b0;
    end else begin
      if (free1)  s1_vq_q  <= in_acc;
      if (free2)  s2_vq_q  <= s1_vq_q;
      if (free3)  s3_vq_q  <= s2_vq_q;
      if (out_en) out_vq_q <= s3_vq_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: address generation. The write position and feedback position
  // advance on every input beat; the fill flags record the first wrap, after
  // which every entry of that store has been written.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] pos_q, dmod, rd_addr;
  logic [FP_W-1:0]   fp_q;
  logic              line_full_q, fb_wrap_q;
  logic [FP_W-1:0]   s1_fp_q, s2_fp_q, s3_fp_q;

  assign dmod    = ADDR_W'(delay_q);
  assign rd_addr = pos_q - dmod;

  // The feedback value an item needs is written when the item FEEDBACK_LAG
  // earlier leaves the last stage; hold the input while that item is in flight.
  assign fb_hazard = (s1_vq_q && s1_fp_q == fp_q) ||
                     (s2_vq_q && s2_fp_q == fp_q) ||
                     (s3_vq_q && s3_fp_q == fp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fp_q        <= '0;
      line_full_q <= 1'b0;
      fb_wrap_q   <= 1'b0;
    end else if (in_acc) begin
      pos_q <= pos_q + 1'b1;
      fp_q  <= (fp_q == FpLast) ? '0 : fp_q + 1'b1;
      if (pos_q == '1)     line_full_q <= 1'b1;
      if (fp_q == FpLast)  fb_wrap_q   <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers: the sample and its bookkeeping, while both stores
  // return their read words.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s1_x_q;
  logic [ADDR_W-1:0]    s1_pos_q;
  logic                 s1_dz_q;   // delay of zero: read own line input
  logic                 s1_d1_q;   // delay of one: previous line input
  logic                 s1_rok_q;  // line entry written before
  logic                 s1_fok_q;  // feedback entry written before

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q   <= sample_in_i;
      s1_pos_q <= pos_q;
      s1_fp_q  <= fp_q;
      s1_dz_q  <= (dmod == '0);
      s1_d1_q  <= (dmod == ADDR_W'(1));
      s1_rok_q <= line_full_q || (dmod <= pos_q);
      s1_fok_q <= fb_wrap_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free2) s2_fp_q <= s1_fp_q;
    if (free3) s3_fp_q <= s2_fp_q;
  end

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic [SW-1:0]        line_rdata, fb_rdata;
  logic                 line_we, fb_we;
  logic signed [SW-1:0] line_in, fb_wdata, y;

  assign line_we = s1_vq_q && free2;
  assign fb_we   = s3_vq_q && out_en;

  fed_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (SW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_pos_q),
    .wdata_i (line_in),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (line_rdata)
  );

  fed_ram #(
    .DEPTH (FEEDBACK_LAG),
    .WIDTH (SW)
  ) u_fb (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (s3_fp_q),
    .wdata_i (fb_wdata),
    .re_i    (in_acc),
    .raddr_i (fp_q),
    .rdata_o (fb_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 logic: saturated line input, written back as the item moves on.
  // The wet sample bypasses the store when the delay is zero (own input) or
  // one (the previous input, whose write can land in the same cycle as this
  // item's read). Unwritten entries read as zero.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] fb_val, wet, last_in_q;
  logic signed [SW:0]   line_sum;

  assign fb_val   = s1_fok_q ? $signed(fb_rdata) : '0;
  assign line_sum = {s1_x_q[SW-1], s1_x_q} + {fb_val[SW-1], fb_val};

  always_comb begin
    if (line_sum[SW] != line_sum[SW-1]) begin
      line_in = line_sum[SW] ? SMin : SMax;
    end else begin
      line_in = line_sum[SW-1:0];
    end
    if (s1_dz_q) begin
      wet = line_in;
    end else if (!s1_rok_q) begin
      wet = '0;
    end else if (s1_d1_q) begin
      wet = last_in_q;
    end else begin
      wet = $signed(line_rdata);
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we) last_in_q <= line_in;
  end

  // ---------------------------------------------------------------------------
  // Stages 2 and 3: multiplies, then feedback value and crossfade
  // ---------------------------------------------------------------------------
  fed_mac #(
    .SW (SW)
  ) u_mac (
    .clk_i (clk_i),
    .adv_i (adv),
    .x_i   (s1_x_q),
    .wet_i (wet),
    .fbk_i (fbk_q),
    .mix_i (mix_q),
    .fb_o  (fb_wdata),
    .y_o   (y)
  );

  // Output register: holds the beat until it is taken
  logic signed [SW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (out_en && s3_vq_q) out_q <= y;
  end

  assign out_valid_o  = out_vq_q;
  assign sample_out_o = out_q;

`ifndef SYNTH
  // Write position advances by exactly one per input beat
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pos_q == ADDR_W'($past(pos_q) + 1'b1))
    else $error("write position did not advance by one");

  // Once the line has wrapped it stays full
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_full_q |=> line_full_q)
    else $error("line fill flag dropped");

  // The hazard check keeps a feedback write off the entry stage 1 has read
  a_fb_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fb_we && s1_vq_q) |-> s1_fp_q != s3_fp_q)
    else $error("feedback write overtakes a pending read");
`endif

endmodule

// ----- design/fed_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module fed_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fed_mac.sv -----
// Gain multiplies, crossfade sum and saturation of the echo datapath.
`timescale 1ns / 1ps
module fed_mac import fed_pkg::*; #(
  parameter int unsigned SW = 16
) (
  input  logic                 clk_i,
  input  fed_adv_t             adv_i,
  input  logic signed [SW-1:0] x_i,
  input  logic signed [SW-1:0] wet_i,
  input  logic [GainW-1:0]     fbk_i,
  input  logic [MixW-1:0]      mix_i,
  output logic signed [SW-1:0] fb_o,
  output logic signed [SW-1:0] y_o
);

  localparam int unsigned PfW = SW + GainW + 1;
  localparam int unsigned PmW = SW + MixW + 1;
  localparam int unsigned SumW = PmW + 1;
  localparam int unsigned FbShW = PfW - FracW;
  localparam int unsigned YShW = SumW - FracW;
  localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0]    x2_q, wet2_q;
  logic signed [PfW-1:0]   pf_q;
  logic signed [PmW-1:0]   pd_q, pw_q;
  logic signed [GainW:0]   fbk_s;
  logic signed [MixW:0]    mix_s, dry_s;
  logic [MixW-1:0]         dry;
  logic signed [SumW-1:0]  ysum;
  logic signed [FbShW-1:0] fb_sh;
  logic signed [YShW-1:0]  y_sh;

  assign dry   = MixFull - mix_i;
  assign fbk_s = $signed({1'b0, fbk_i});
  assign mix_s = $signed({1'b0, mix_i});
  assign dry_s = $signed({1'b0, dry});

  // Stage 2: hold operands
  always_ff @(posedge clk_i) begin
    if (adv_i.ld2) begin
      x2_q   <= x_i;
      wet2_q <= wet_i;
    end
  end

  // Stage 3: products, one register after each multiply
  always_ff @(posedge clk_i) begin
    if (adv_i.ld3) begin
      pf_q <= wet2_q * fbk_s;
      pd_q <= x2_q * dry_s;
      pw_q <= wet2_q * mix_s;
    end
  end

  // Arithmetic shift right by the fraction width, then clamp
  assign ysum  = SumW'(pd_q) + SumW'(pw_q);
  assign fb_sh = pf_q[PfW-1:FracW];
  assign y_sh  = ysum[SumW-1:FracW];

  always_comb begin
    if (fb_sh[FbShW-1:SW-1] == '0 || fb_sh[FbShW-1:SW-1] == '1) begin
      fb_o = fb_sh[SW-1:0];
    end else begin
      fb_o = fb_sh[FbShW-1] ? SMin : SMax;
    end
    if (y_sh[YShW-1:SW-1] == '0 || y_sh[YShW-1:SW-1] == '1) begin
      y_o = y_sh[SW-1:0];
    end else begin
      y_o = y_sh[YShW-1] ? SMin : SMax;
    end
  end

endmodule
